@@ hdl/jet_pkg.sv @@
`timescale 1ns / 1ps

package jet_pkg;

  localparam int CoordW  = 10;
  localparam int IterW   = 9;
  localparam int FixW    = 32;
  localparam int MulW    = FixW + 1;
  localparam int ProdW   = 2 * MulW;
  localparam int SumW    = ProdW + 1;
  localparam int NumMul  = 3;
  localparam int CfgIdxW = 3;
  localparam int FracW   = 24;

  // |z|^2 >= 16 in Q16.48 is 2^52.
  localparam logic [63:0] EscapeBound = 64'h0010_0000_0000_0000;

  typedef logic signed [FixW-1:0]  fix_t;
  typedef logic signed [MulW-1:0]  mul_op_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef struct packed {
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [IterW-1:0] iterations;
    logic             escaped;
  } result_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReStart = 3'd0,
    CfgReEnd   = 3'd1,
    CfgImStart = 3'd2,
    CfgImEnd   = 3'd3,
    CfgCReal   = 3'd4,
    CfgCImag   = 3'd5
  } cfg_idx_e;

  // Clamp a wide signed value into the Q8.24 range.
  function automatic fix_t sat_fix(input sum_t x);
    logic [SumW-FixW:0] top;
    top = x[SumW-1:FixW-1];
    if (top == '0 || top == '1) begin
      return x[FixW-1:0];
    end else if (x[SumW-1]) begin
      return {1'b1, {(FixW-1){1'b0}}};
    end else begin
      return {1'b0, {(FixW-1){1'b1}}};
    end
  endfunction

endpackage

@@ hdl/jet_pix_if.sv @@
`timescale 1ns / 1ps

interface jet_pix_if
  import jet_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/jet_res_if.sv @@
`timescale 1ns / 1ps

interface jet_res_if
  import jet_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/jet_cmul.sv @@
`timescale 1ns / 1ps

// Three signed multipliers with registered products, shared between the
// coordinate mapping and the complex squaring.
module jet_cmul
  import jet_pkg::*;
(
  input  logic    clk_i,
  input  mul_op_t op_a_i [NumMul],
  input  mul_op_t op_b_i [NumMul],
  output prod_t   prod_o [NumMul]
);

  prod_t prod_q [NumMul];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumMul; k++) begin
      prod_q[k] <= op_a_i[k] * op_b_i[k];
    end
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/julia_escape_time.sv @@
`timescale 1ns / 1ps

// Julia set escape-time engine in signed Q8.24. Each pixel transfer (column,
// row) is mapped linearly into the window held in the configuration
// registers, with row 0 at the top edge, and z = z*z + c is iterated until
// |z| reaches 4 or ITER_LIMIT iterations are done; one result transfer gives
// the count (low 9 bits) and an escaped flag. The block works on one pixel at
// a time: after the input transfer it maps the coordinates (StMapMul, then
// StMapAdd) and then runs each magnitude test as StIterMul, which forms the
// three products in the shared multiplier bank, then StIterChk, which tests
// and updates z. A new pixel is taken only once the result has moved into
// the output register and the block is back in StIdle. A finished result
// waits in an output register; the block only stalls if a new result is
// ready before the previous one has been taken.
// The user must write the configuration registers only while no pixel is
// in flight; the block itself does not enforce this.
module julia_escape_time
  import jet_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024,
  parameter int ITER_LIMIT   = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [FixW-1:0]    cfg_data_i,
  jet_pix_if.sink            pix_i,
  jet_res_if.source          res_o
);

  // Dividing by the image size rounds it down to a power of two.
  localparam int ShiftX = $clog2(IMAGE_WIDTH + 1) - 1;
  localparam int ShiftY = $clog2(IMAGE_HEIGHT + 1) - 1;
  localparam int CountW = $clog2(ITER_LIMIT + 1);

  typedef enum logic [2:0] {
    StIdle,
    StMapMul,
    StMapAdd,
    StIterMul,
    StIterChk
  } state_e;

  state_e  state_q;
  fix_t    re_start_q, re_end_q, im_start_q, im_end_q, c_real_q, c_imag_q;
  pixel_t  pix_q;
  mul_op_t diff_re_q, diff_im_q;
  fix_t    re_q, im_q;
  logic [CountW-1:0] count_q;
  logic    out_valid_q;
  result_t result_q;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_start_q <= -32'sd33554432;
      re_end_q   <= 32'sd33554432;
      im_start_q <= -32'sd33554432;
      im_end_q   <= 32'sd33554432;
      c_real_q   <= '0;
      c_imag_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgReStart: re_start_q <= cfg_data_i;
        CfgReEnd:   re_end_q   <= cfg_data_i;
        CfgImStart: im_start_q <= cfg_data_i;
        CfgImEnd:   im_end_q   <= cfg_data_i;
        CfgCReal:   c_real_q   <= cfg_data_i;
        CfgCImag:   c_imag_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The multiplier bank takes the window spans times the pixel position
  // while mapping, and re*re, im*im, re*im while iterating.
  mul_op_t op_a [NumMul];
  mul_op_t op_b [NumMul];
  prod_t   prod [NumMul];

  always_comb begin
    op_a[0] = MulW'(re_q);
    op_b[0] = MulW'(re_q);
    op_a[1] = MulW'(im_q);
    op_b[1] = MulW'(im_q);
    op_a[2] = MulW'(re_q);
    op_b[2] = MulW'(im_q);
    if (state_q == StMapMul) begin
      op_a[0] = diff_re_q;
      op_b[0] = $signed({{(MulW-CoordW){1'b0}}, pix_q.column});
      op_a[1] = diff_im_q;
      op_b[1] = $signed({{(MulW-CoordW){1'b0}}, pix_q.row});
    end
  end

  jet_cmul u_cmul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Mapping: start point from the registered span products.
  sum_t map_re_sum, map_im_sum;
  assign map_re_sum = SumW'(re_start_q) + SumW'(prod[0] >>> ShiftX);
  assign map_im_sum = SumW'(im_end_q) - SumW'(prod[1] >>> ShiftY);

  // Iteration: magnitude test on the full squares, then the next z.
  logic [63:0] mag_sq;
  sum_t        sq_diff, next_re_sum, next_im_sum;
  logic        escape, at_limit, out_free, done;

  assign mag_sq      = prod[0][63:0] + prod[1][63:0];
  assign escape      = (mag_sq >= EscapeBound);
  assign at_limit    = (count_q >= CountW'(ITER_LIMIT));
  assign sq_diff     = SumW'(prod[0]) - SumW'(prod[1]);
  assign next_re_sum = SumW'(sq_diff >>> FracW) + SumW'(c_real_q);
  assign next_im_sum = SumW'(prod[2] >>> (FracW - 1)) + SumW'(c_imag_q);
  assign out_free    = !out_valid_q || res_o.ready;
  // The result of the current pixel moves into the output register.
  assign done        = (state_q == StIterChk) && (escape || at_limit) && out_free;

  assign pix_i.ready   = (state_q == StIdle);
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      pix_q       <= '0;
      diff_re_q   <= '0;
      diff_im_q   <= '0;
      re_q        <= '0;
      im_q        <= '0;
      result_q    <= '0;
    end else begin
      // A new result takes the place of one that leaves in the same cycle.
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pix_i.valid) begin
            pix_q     <= pix_i.payload;
            diff_re_q <= MulW'(re_end_q) - MulW'(re_start_q);
            diff_im_q <= MulW'(im_end_q) - MulW'(im_start_q);
            state_q   <= StMapMul;
          end
        end
        StMapMul: begin
          state_q <= StMapAdd;
        end
        StMapAdd: begin
          re_q    <= sat_fix(map_re_sum);
          im_q    <= sat_fix(map_im_sum);
          count_q <= '0;
          state_q <= StIterMul;
        end
        StIterMul: begin
          state_q <= StIterChk;
        end
        StIterChk: begin
          if (escape || at_limit) begin
            // Hold here until the output register can take the result.
            if (out_free) begin
              result_q.iterations <= IterW'(count_q);
              result_q.escaped    <= escape;
              state_q             <= StIdle;
            end
          end else begin
            re_q    <= sat_fix(next_re_sum);
            im_q    <= sat_fix(next_im_sum);
            count_q <= count_q + 1'b1;
            state_q <= StIterMul;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ sim/julia_escape_time_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the Julia escape-time engine. Pixels are sent over
// the pixel channel from a queue, and every accepted pixel transfer is run
// through a bit-true model of the mapping and the iteration loop. The
// result is queued as the value that the next result transfer must carry.
// Configuration is only changed while nothing is in flight. That happens
// after reset and between phases, once every due result has been taken.
module julia_escape_time_test;
  import jet_pkg::*;

  localparam int ImgWidth  = 1024;
  localparam int ImgHeight = 1024;
  localparam int IterLimit = 256;

  // The mapping divides by the largest power of two not above the image size.
  localparam int ColShift = $clog2(ImgWidth + 1) - 1;
  localparam int RowShift = $clog2(ImgHeight + 1) - 1;

  // Saturation bounds of Q8.24, and |z|^2 >= 16 expressed in Q16.48.
  localparam longint      QMax     = 64'sd2147483647;
  localparam longint      QMin     = -64'sd2147483648;
  localparam logic [64:0] MagBound = 65'd1 << 52;

  localparam fix_t FixTwo     = 32'sh0200_0000;
  localparam fix_t FixEight   = 32'sh0800_0000;
  localparam fix_t FixQuarter = 32'sh0040_0000;
  localparam fix_t FixHundredth = 32'sh0002_8F5C;

  // Register indexes beyond the last register; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  localparam int RandPhases   = 11;
  localparam int RandPerPhase = 50;
  localparam int IdlePercent  = 21;
  localparam int MaxPrinted   = 200;

  // Worst case per pixel: the full iteration loop plus generous stall room,
  // for every directed and random pixel, taken four times over.
  localparam int CycleLimit = 600 * (2 * IterLimit + 5 + 64) * 4;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [FixW-1:0]     cfg_data_i;

  jet_pix_if pix ();
  jet_res_if res ();

  julia_escape_time #(
    .IMAGE_WIDTH (ImgWidth),
    .IMAGE_HEIGHT(ImgHeight),
    .ITER_LIMIT  (IterLimit)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .res_o     (res)
  );

  // Shadow copy of the configuration registers, as the engine should hold them.
  fix_t re_lo, re_hi, im_lo, im_hi, c_re, c_im;

  pixel_t  pixels_to_send[$];
  result_t results_due[$];
  result_t want;
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  function automatic longint clamp_q(input longint x);
    if (x > QMax) return QMax;
    if (x < QMin) return QMin;
    return x;
  endfunction

  // Escape-time computation for one pixel with the current shadow registers.
  // All shifts are arithmetic, so every division rounds toward minus infinity.
  function automatic result_t julia_escape(input pixel_t px);
    longint          zr, zi, nr, ni;
    logic [63:0]     rr, ii;
    logic [64:0]     mag;
    int unsigned     n;
    logic            esc;
    result_t         r;
    zr = clamp_q(longint'(re_lo)
                 + ((longint'(px.column) * (longint'(re_hi) - longint'(re_lo))) >>> ColShift));
    zi = clamp_q(longint'(im_hi)
                 - ((longint'(px.row) * (longint'(im_hi) - longint'(im_lo))) >>> RowShift));
    n = 0;
    esc = 1'b0;
    forever begin
      rr = zr * zr;
      ii = zi * zi;
      mag = {1'b0, rr} + {1'b0, ii};
      // The magnitude is tested before the count, so an escape on the last
      // allowed test still counts as an escape.
      if (mag >= MagBound) begin
        esc = 1'b1;
        break;
      end
      if (n >= IterLimit) break;
      nr = clamp_q(((longint'(rr) - longint'(ii)) >>> FracW) + longint'(c_re));
      ni = clamp_q(((zr * zi) >>> (FracW - 1)) + longint'(c_im));
      zr = nr;
      zi = ni;
      n++;
    end
    r.iterations = n[IterW-1:0];
    r.escaped = esc;
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input fix_t value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CfgReStart: re_lo = value;
      CfgReEnd:   re_hi = value;
      CfgImStart: im_lo = value;
      CfgImEnd:   im_hi = value;
      CfgCReal:   c_re = value;
      CfgCImag:   c_im = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input fix_t re_s, input fix_t re_e, input fix_t im_s,
                            input fix_t im_e, input fix_t k_re, input fix_t k_im);
    write_reg(CfgReStart, re_s);
    write_reg(CfgReEnd, re_e);
    write_reg(CfgImStart, im_s);
    write_reg(CfgImEnd, im_e);
    write_reg(CfgCReal, k_re);
    write_reg(CfgCImag, k_im);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row);
    pixel_t p;
    p.column = col;
    p.row = row;
    pixels_to_send.push_back(p);
  endtask

  // Holds the caller until every queued pixel has been sent and every due
  // result has come back; the engine is then idle.
  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || pix.valid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Pixel driver. The expected result of a pixel is worked out at the edge
  // where its transfer happens, so it always sees the configuration in force.
  // The next pixel is offered once the current one is gone, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        results_due.push_back(julia_escape(pix.payload));
      end
      if (!pix.valid || pix.ready) begin
        if (pixels_to_send.size() != 0 &&
            (no_idle || $urandom_range(99) >= IdlePercent)) begin
          pix.valid <= 1'b1;
          pix.payload <= pixels_to_send.pop_front();
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result transfer is checked against the oldest due
  // result; ready is withdrawn at random to make the engine hold its result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d/%0b with no pixel outstanding",
                                  res.payload.iterations, res.payload.escaped));
        end else begin
          want = results_due.pop_front();
          if (res.payload.iterations !== want.iterations) begin
            flag_mismatch($sformatf("iterations %0d, want %0d",
                                    res.payload.iterations, want.iterations));
          end
          if (res.payload.escaped !== want.escaped) begin
            flag_mismatch($sformatf("escaped %0b, want %0b (iterations %0d)",
                                    res.payload.escaped, want.escaped, want.iterations));
          end
        end
      end
      res.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fix_t    edge_lo, edge_hi, edge_mid, edge_c;
    pixel_t  centre;
    result_t probe;
    fix_t    w [6];
    int      half, ctr_re, ctr_im, steady_phase;

    // Configuration inputs are known from time zero; the shadow starts at
    // reset values.
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgReStart;
    cfg_data_i = '0;
    re_lo = -FixTwo;
    re_hi = FixTwo;
    im_lo = -FixTwo;
    im_hi = FixTwo;
    c_re = '0;
    c_im = '0;
    steady_phase = $urandom_range(RandPhases - 1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: the default window with c = 0. The image center
    // maps to z = 0, which never moves and so runs the full iteration limit.
    @(negedge clk_i);
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd1023, 10'd1023);
    queue_pixel(10'd1023, 10'd0);
    queue_pixel(10'd0, 10'd1023);
    queue_pixel(10'd512, 10'd512);
    queue_pixel(10'h155, 10'h2AA);
    queue_pixel(10'h2AA, 10'h155);
    queue_pixel(10'd768, 10'd256);
    wait_idle();

    // Find the smallest c on the real axis just above 1/4 for which the
    // origin escapes within the limit. Near that parabolic point the escape
    // time grows without bound, so the first escaping c escapes on the very
    // last allowed magnitude test. The shadow is probed here without touching
    // the engine; it is idle and holds the reset values.
    centre.column = 10'd512;
    centre.row = 10'd512;
    edge_lo = FixQuarter;
    edge_hi = FixQuarter + FixHundredth;
    while (edge_hi - edge_lo > 1) begin
      edge_mid = edge_lo + (edge_hi - edge_lo) / 2;
      c_re = edge_mid;
      probe = julia_escape(centre);
      if (probe.escaped) begin
        edge_hi = edge_mid;
      end else begin
        edge_lo = edge_mid;
      end
    end
    edge_c = edge_hi;
    c_re = '0;

    // Writes to indexes past the last register must leave everything as is.
    // A window of +-8 puts the corners outside |z| = 4 before any iteration.
    write_reg(CfgSpareLo, 32'shDEAD_BEEF);
    write_reg(CfgSpareHi, 32'sh1234_5678);
    set_config(-FixEight, FixEight, -FixEight, FixEight, '0, '0);
    @(negedge clk_i);
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd512, 10'd512);
    queue_pixel(10'd1023, 10'd1023);
    queue_pixel(10'd300, 10'd700);
    wait_idle();

    // Full-range window and extreme constants, all at the limits of Q8.24.
    set_config(fix_t'(QMin), fix_t'(QMax), fix_t'(QMin), fix_t'(QMax),
               fix_t'(QMax), fix_t'(QMin));
    @(negedge clk_i);
    queue_pixel(10'd512, 10'd512);
    queue_pixel(10'd516, 10'd508);
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd1023, 10'd1023);
    wait_idle();

    // Escape on the last allowed test, then no escape with c just below it.
    set_config(-FixTwo, FixTwo, -FixTwo, FixTwo, edge_c, '0);
    @(negedge clk_i);
    queue_pixel(10'd512, 10'd512);
    wait_idle();
    set_config(-FixTwo, FixTwo, -FixTwo, FixTwo, edge_lo, '0);
    @(negedge clk_i);
    queue_pixel(10'd512, 10'd512);
    wait_idle();

    // Random phases. Most use a window of random size around a point near the
    // origin and a constant within +-1.5, where the escape times spread
    // widely; some mirror the real axis; some take raw 32-bit values for
    // every register. One phase runs with no gaps on either side.
    for (int ph = 0; ph < RandPhases; ph++) begin
      if ($urandom_range(3) == 0) begin
        for (int k = 0; k < 6; k++) begin
          w[k] = $urandom;
        end
      end else begin
        half = $urandom_range(1 << 20, 3 << 24);
        ctr_re = int'($urandom_range(0, 2 << 24)) - (1 << 24);
        ctr_im = int'($urandom_range(0, 2 << 24)) - (1 << 24);
        w[0] = ctr_re - half;
        w[1] = ctr_re + half;
        w[2] = ctr_im - half;
        w[3] = ctr_im + half;
        if ($urandom_range(3) == 0) begin
          w[0] = ctr_re + half;
          w[1] = ctr_re - half;
        end
        w[4] = int'($urandom_range(0, 3 << 24)) - (3 << 23);
        w[5] = int'($urandom_range(0, 3 << 24)) - (3 << 23);
      end
      set_config(w[0], w[1], w[2], w[3], w[4], w[5]);
      no_idle = (ph == steady_phase);
      @(negedge clk_i);
      repeat (RandPerPhase) begin
        queue_pixel(CoordW'($urandom_range(1023)), CoordW'($urandom_range(1023)));
      end
      wait_idle();
    end

    // Allow one full pixel time for any stray result to show up.
    no_idle = 1'b0;
    repeat (2 * IterLimit + 8) @(posedge clk_i);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/jet_pkg.sv
hdl/jet_pix_if.sv
hdl/jet_res_if.sv
hdl/jet_cmul.sv
hdl/julia_escape_time.sv
sim/julia_escape_time_test.sv
